// ----- hw/rtl/jeo_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeo_pkg
// Shared widths and controller/datapath signal groups for the Josephus
// elimination order block.
// ----------------------------------------------------------------------------
package jeo_pkg;

  localparam int LBL_W     = 7;
  localparam int STEP_W    = 10;
  localparam int MOD_CNT_W = $clog2(STEP_W);

  typedef struct packed {
    logic load;
    logic mod_step;
    logic walk;
    logic final_emit;
  } jeo_cmd_t;

  typedef struct packed {
    logic in_n_zero;
    logic in_n_one;
    logic mod_last;
    logic victim;
    logic last_kill;
    logic out_free;
  } jeo_sts_t;

endpackage

// ----- hw/rtl/jeo_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeo_in_if / jeo_out_if
// Valid/ready channels for requests and for elimination results.
// ----------------------------------------------------------------------------
interface jeo_in_if;
  logic                        valid;
  logic                        ready;
  logic [jeo_pkg::LBL_W-1:0]   people_count;
  logic [jeo_pkg::STEP_W-1:0]  step_count;

  modport source (output valid, output people_count, output step_count, input ready);
  modport sink   (input valid, input people_count, input step_count, output ready);
endinterface

interface jeo_out_if;
  logic                      valid;
  logic                      ready;
  logic [jeo_pkg::LBL_W-1:0] label;
  logic                      last;

  modport source (output valid, output label, output last, input ready);
  modport sink   (input valid, input label, input last, output ready);
endinterface

// ----- hw/rtl/jeo_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeo_ctrl
// Sequencer: request load, step-modulo iterations, ring walk, survivor.
// ----------------------------------------------------------------------------
module jeo_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_rdy,
  input  jeo_pkg::jeo_sts_t sts,
  output jeo_pkg::jeo_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MOD   = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_FINAL = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_rdy         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_rdy   = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          if (sts.in_n_zero) begin
            state_nxt = ST_IDLE;
          end else if (sts.in_n_one) begin
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // hold the walk while a removal has no free output slot
        cmd.walk = !(sts.victim && !sts.out_free);
        if (cmd.walk && sts.victim) begin
          state_nxt = sts.last_kill ? ST_FINAL : ST_MOD;
        end
      end
      ST_FINAL: begin
        cmd.final_emit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hw/rtl/jeo_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jeo_dp
// Datapath: alive bitmap, ring pointers, shift-subtract modulo unit and
// output register.
// ----------------------------------------------------------------------------
module jeo_dp #(
  parameter int MAX_PEOPLE = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [jeo_pkg::LBL_W-1:0]   in_people_count,
  input  logic [jeo_pkg::STEP_W-1:0]  in_step_count,
  input  jeo_pkg::jeo_cmd_t           cmd,
  output jeo_pkg::jeo_sts_t           sts,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [jeo_pkg::LBL_W-1:0]   out_label,
  output logic                        out_last
);

  localparam int SLOT_W = $clog2(MAX_PEOPLE);
  localparam int CNT_W  = $clog2(MAX_PEOPLE + 1);

  logic [MAX_PEOPLE-1:0]          alive_r, alive_nxt;
  logic [SLOT_W-1:0]              w_r, w_nxt;
  logic [SLOT_W-1:0]              pos_r, pos_nxt;
  logic [SLOT_W-1:0]              last_r, last_nxt;
  logic [CNT_W-1:0]               rem_r, rem_nxt;
  logic [CNT_W-1:0]               left_r, left_nxt;
  logic [CNT_W-1:0]               part_r, part_nxt;
  logic [jeo_pkg::STEP_W-1:0]     div_r, div_nxt;
  logic [jeo_pkg::STEP_W-1:0]     mm1_r, mm1_nxt;
  logic [jeo_pkg::MOD_CNT_W-1:0]  mcnt_r, mcnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [jeo_pkg::LBL_W-1:0]      out_label_r, out_label_nxt;
  logic                           out_last_r, out_last_nxt;

  logic [CNT_W-1:0]               n_in;
  logic [jeo_pkg::STEP_W-1:0]     mm1_in;
  logic [CNT_W:0]                 shv;
  logic [CNT_W:0]                 rem_x;
  logic [CNT_W-1:0]               part_new;
  logic [SLOT_W-1:0]              s_slot;
  logic                           alive_s;
  logic                           out_free;

  assign n_in   = (in_people_count > jeo_pkg::LBL_W'(MAX_PEOPLE)) ?
                  CNT_W'(MAX_PEOPLE) : CNT_W'(in_people_count);
  assign mm1_in = (in_step_count == '0) ? '0 :
                  in_step_count - jeo_pkg::STEP_W'(1);

  assign shv      = {part_r, div_r[jeo_pkg::STEP_W-1]};
  assign rem_x    = (CNT_W+1)'(rem_r);
  assign part_new = (shv >= rem_x) ? CNT_W'(shv - rem_x) : CNT_W'(shv);

  assign s_slot   = (w_r == last_r) ? '0 : w_r + SLOT_W'(1);
  assign alive_s  = alive_r[s_slot];
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    sts.in_n_zero = (in_people_count == '0);
    sts.in_n_one  = (in_people_count == jeo_pkg::LBL_W'(1));
    sts.mod_last  = (mcnt_r == jeo_pkg::MOD_CNT_W'(jeo_pkg::STEP_W - 1));
    sts.victim    = alive_s && (left_r == CNT_W'(1));
    sts.last_kill = (rem_r == CNT_W'(2));
    sts.out_free  = out_free;
  end

  always_comb begin
    alive_nxt     = alive_r;
    w_nxt         = w_r;
    pos_nxt       = pos_r;
    last_nxt      = last_r;
    rem_nxt       = rem_r;
    left_nxt      = left_r;
    part_nxt      = part_r;
    div_nxt       = div_r;
    mm1_nxt       = mm1_r;
    mcnt_nxt      = mcnt_r;
    out_label_nxt = out_label_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.load) begin
      for (int i = 0; i < MAX_PEOPLE; i++) begin
        alive_nxt[i] = (CNT_W'(i) < n_in);
      end
      last_nxt = SLOT_W'(n_in - CNT_W'(1));
      w_nxt    = SLOT_W'(n_in - CNT_W'(1));
      pos_nxt  = SLOT_W'(n_in - CNT_W'(1));
      rem_nxt  = n_in;
      mm1_nxt  = mm1_in;
      div_nxt  = mm1_in;
      part_nxt = '0;
      mcnt_nxt = '0;
    end

    if (cmd.mod_step) begin
      part_nxt = part_new;
      div_nxt  = {div_r[jeo_pkg::STEP_W-2:0], 1'b0};
      mcnt_nxt = mcnt_r + jeo_pkg::MOD_CNT_W'(1);
      if (sts.mod_last) begin
        left_nxt = part_new + CNT_W'(1);
      end
    end

    if (cmd.walk) begin
      w_nxt = s_slot;
      if (alive_s) begin
        if (left_r == CNT_W'(1)) begin
          alive_nxt[s_slot] = 1'b0;
          rem_nxt           = rem_r - CNT_W'(1);
          out_valid_nxt     = 1'b1;
          out_label_nxt     = jeo_pkg::LBL_W'(s_slot) + jeo_pkg::LBL_W'(1);
          out_last_nxt      = 1'b0;
          div_nxt           = mm1_r;
          part_nxt          = '0;
          mcnt_nxt          = '0;
        end else begin
          pos_nxt  = s_slot;
          left_nxt = left_r - CNT_W'(1);
        end
      end
    end

    if (cmd.final_emit) begin
      alive_nxt[pos_r] = 1'b0;
      rem_nxt          = '0;
      out_valid_nxt    = 1'b1;
      out_label_nxt    = jeo_pkg::LBL_W'(pos_r) + jeo_pkg::LBL_W'(1);
      out_last_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alive_r     <= '0;
      w_r         <= '0;
      pos_r       <= '0;
      rem_r       <= '0;
      left_r      <= '0;
      mcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      alive_r     <= alive_nxt;
      w_r         <= w_nxt;
      pos_r       <= pos_nxt;
      rem_r       <= rem_nxt;
      left_r      <= left_nxt;
      mcnt_r      <= mcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_r      <= last_nxt;
    part_r      <= part_nxt;
    div_r       <= div_nxt;
    mm1_r       <= mm1_nxt;
    out_label_r <= out_label_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_label = out_label_r;
  assign out_last  = out_last_r;

endmodule

// ----- hw/rtl/josephus_elimination_order_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// josephus_elimination_order_top
// Emits the Josephus elimination order of a ring of n people with step m,
// removals first, survivor last.
//
//   channel  dir  payload                      transfer
//   in_ch    in   people_count[6:0], step[9:0] valid & ready
//   out_ch   out  label[6:0], last             valid & ready
//
// A request is taken only while no run is in progress; a request with n = 0
// produces nothing. Each removal first runs the shift-subtract modulo unit, then
// walks the ring slot by slot up to the victim. Results leave through a
// one-entry output register; a removal waits while it is full and not taken.
// Reset is synchronous, active low, and clears the alive bitmap at once.
// ----------------------------------------------------------------------------
module josephus_elimination_order_top #(
  parameter int MAX_PEOPLE = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  jeo_in_if.sink     in_ch,
  jeo_out_if.source  out_ch
);

  jeo_pkg::jeo_cmd_t cmd;
  jeo_pkg::jeo_sts_t sts;
  logic              in_rdy;

  jeo_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_rdy   (in_rdy),
    .sts      (sts),
    .cmd      (cmd)
  );

  jeo_dp #(
    .MAX_PEOPLE (MAX_PEOPLE)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_people_count (in_ch.people_count),
    .in_step_count   (in_ch.step_count),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_label       (out_ch.label),
    .out_last        (out_ch.last)
  );

  assign in_ch.ready = in_rdy;

endmodule

// ----- verif/tb_josephus_elimination_order_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_josephus_elimination_order_top
// Feeds ring-size / step requests into the Josephus elimination order block
// and checks every emitted label and survivor flag against an in-bench
// elimination predictor. The sender runs in bursts with random gaps. The
// receiver stalls on a changing pattern, with one long hold-off, and the
// sender waits for the results to drain at a few points.
// ----------------------------------------------------------------------------
module tb_josephus_elimination_order_top;

  localparam int RING_SLOTS     = 64;
  localparam int RANDOM_ITEMS   = 120;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 120;
  localparam int TAIL_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTS     = 30;

  typedef struct packed {
    logic [jeo_pkg::LBL_W-1:0] label;
    logic                      last;
  } elim_result_t;

  typedef struct packed {
    logic [jeo_pkg::LBL_W-1:0]  people;
    logic [jeo_pkg::STEP_W-1:0] step;
    logic                       drain;
  } ring_request_t;

  typedef enum logic [1:0] {
    RDY_OPEN,
    RDY_COIN,
    RDY_SPARSE,
    RDY_CADENCE
  } ready_mode_t;

  logic clk;
  logic rst_n;

  jeo_in_if  in_if ();
  jeo_out_if out_if ();

  josephus_elimination_order_top #(
    .MAX_PEOPLE (RING_SLOTS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  ring_request_t request_q[$];
  elim_result_t  order_q[$];

  int err_cnt      = 0;
  int req_cnt      = 0;
  int results_seen = 0;
  int outstanding  = 0;
  int drain_cnt    = 0;
  int total_reqs   = 0;
  int idle_cycles  = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int next_alive(input logic [RING_SLOTS-1:0] ring, input int p);
    int s;
    for (int i = 1; i <= RING_SLOTS; i++) begin
      s = (p + i) % RING_SLOTS;
      if (ring[s]) return s;
    end
    return p % RING_SLOTS;
  endfunction

  // Expected elimination order, survivor last.
  task automatic predict_elimination(input logic [jeo_pkg::LBL_W-1:0] n_raw,
                                     input logic [jeo_pkg::STEP_W-1:0] m_raw);
    logic [RING_SLOTS-1:0] ring;
    int                    n;
    int                    m;
    int                    pos;
    int                    rem;
    int                    skip;
    int                    victim;
    elim_result_t          r;
    n = int'(n_raw);
    m = int'(m_raw);
    if (n == 0) return;
    if (n > RING_SLOTS) n = RING_SLOTS;
    if (m < 1) m = 1;
    ring = '0;
    for (int k = 0; k < n; k++) ring[k] = 1'b1;
    rem = n;
    pos = n - 1;
    while (rem > 1) begin
      skip = (m - 1) % rem;
      for (int k = 0; k < skip; k++) pos = next_alive(ring, pos);
      victim = next_alive(ring, pos);
      ring[victim] = 1'b0;
      rem--;
      r.label = jeo_pkg::LBL_W'(victim + 1);
      r.last  = 1'b0;
      order_q.push_back(r);
    end
    r.label = jeo_pkg::LBL_W'(pos + 1);
    r.last  = 1'b1;
    order_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS)
      $display("MISMATCH %s: expected %0d got %0d (result %0d)", what, want, got,
               results_seen);
  endtask

  task automatic add_request(input int n, input int m, input bit drain);
    ring_request_t rq;
    rq.people = jeo_pkg::LBL_W'(n);
    rq.step   = jeo_pkg::STEP_W'(m);
    rq.drain  = drain;
    request_q.push_back(rq);
    if (drain) drain_cnt++;
  endtask

  // Request driver: bursts with gaps, optional drain wait before an item.
  int burst_left;
  int gap_left;
  bit drain_armed;

  always @(posedge clk) begin : drive_requests
    ring_request_t item;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
      drain_armed <= 1'b0;
    end else if (in_if.valid && !in_if.ready) begin
      // hold until transfer
    end else if (gap_left != 0) begin
      in_if.valid <= 1'b0;
      gap_left    <= gap_left - 1;
    end else if (request_q.size() == 0) begin
      in_if.valid <= 1'b0;
    end else if (request_q[0].drain && !drain_armed) begin
      in_if.valid <= 1'b0;
      drain_armed <= 1'b1;
    end else if (request_q[0].drain && outstanding != 0) begin
      in_if.valid <= 1'b0;
    end else begin
      item = request_q.pop_front();
      in_if.valid        <= 1'b1;
      in_if.people_count <= item.people;
      in_if.step_count   <= item.step;
      drain_armed        <= 1'b0;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 8);
        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  // Result receiver: changing stall pattern plus one long hold-off.
  ready_mode_t rdy_mode;
  int          mode_left;
  int          hold_left;
  bit          hold_done;
  int          cadence;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rdy_mode     <= RDY_OPEN;
      mode_left    <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
      cadence      <= 0;
    end else if (hold_left != 0) begin
      out_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_if.ready <= 1'b0;
      hold_left    <= LONG_HOLD;
      hold_done    <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  <= ready_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(32, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      cadence <= (cadence == 4) ? 0 : cadence + 1;
      case (rdy_mode)
        RDY_OPEN:    out_if.ready <= 1'b1;
        RDY_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE:  out_if.ready <= ($urandom_range(0, 3) == 0);
        default:     out_if.ready <= (cadence != 0);
      endcase
    end
  end

  // Monitor: check results in order, then queue predictions for new requests.
  always @(posedge clk) begin : watch_channels
    elim_result_t want;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (order_q.size() == 0) begin
          report_mismatch("result with none pending, label", 0, int'(out_if.label));
        end else begin
          want = order_q.pop_front();
          if (out_if.label !== want.label)
            report_mismatch("label", int'(want.label), int'(out_if.label));
          if (out_if.last !== want.last)
            report_mismatch("last", int'(want.last), int'(out_if.last));
        end
        results_seen <= results_seen + 1;
      end
      if (in_if.valid && in_if.ready) begin
        predict_elimination(in_if.people_count, in_if.step_count);
        req_cnt <= req_cnt + 1;
      end
      outstanding <= order_q.size();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d idle cycles, %0d results pending", idle_cycles, outstanding);
        $display("tb_josephus_elimination_order_top: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int sel;
    int n;
    int m;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.people_count = '0;
    in_if.step_count   = '0;
    out_if.ready       = 1'b0;

    add_request(1, 1, 0);      // single person
    add_request(1, 0, 0);
    add_request(0, 5, 0);      // empty circle
    add_request(0, 0, 0);
    add_request(2, 1, 0);
    add_request(2, 2, 0);
    add_request(7, 3, 0);
    add_request(5, 0, 0);      // zero step
    add_request(10, 1023, 0);  // long step wraps
    add_request(3, 1000, 1);
    add_request(41, 3, 0);
    add_request(64, 1, 0);
    add_request(64, 1023, 0);
    add_request(127, 1023, 1); // oversized circle saturates
    add_request(65, 2, 0);
    add_request(64, 0, 0);
    add_request(6, 512, 0);
    add_request(8, 'h155, 0);
    add_request(33, 'h2AA, 0);
    add_request(96, 7, 0);
    add_request(4, 4, 1);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 65)      n = $urandom_range(1, 12);
      else if (sel < 83) n = $urandom_range(13, 40);
      else if (sel < 90) n = $urandom_range(41, 64);
      else if (sel < 95) n = $urandom_range(65, 127);
      else               n = 0;
      sel = $urandom_range(0, 99);
      if (sel < 50)      m = $urandom_range(0, 12);
      else if (sel < 80) m = $urandom_range(0, 1023);
      else               m = $urandom_range(13, 100);
      add_request(n, m, $urandom_range(0, 39) == 0);
    end
    total_reqs = request_q.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (req_cnt != total_reqs) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (outstanding != 0) report_mismatch("results never emitted, count", 0, outstanding);

    $display("summary: %0d requests (%0d with drain waits), %0d results checked",
             req_cnt, drain_cnt, results_seen);
    $display("summary: one receiver hold-off of %0d cycles, %0d mismatches",
             LONG_HOLD, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_josephus_elimination_order_top: clean");
    end else begin
      $display("tb_josephus_elimination_order_top: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/jeo_pkg.sv
hw/rtl/jeo_if.sv
hw/rtl/jeo_ctrl.sv
hw/rtl/jeo_dp.sv
hw/rtl/josephus_elimination_order_top.sv
verif/tb_josephus_elimination_order_top.sv
